// File: rtl/pled_pkg.sv
package pled_pkg;

    localparam int CHANNELS_MAX     = 16;
    localparam int CHANNELS_DEFAULT = 16;
    localparam int CFG_INDEX_W      = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIT_PERIOD     = 3'd0,
        CFG_ZERO_HIGH      = 3'd1,
        CFG_ONE_HIGH       = 3'd2,
        CFG_RESET_PERIODS  = 3'd3,
        CFG_CHANNEL_ENABLE = 3'd4
    } cfg_index_t;

    localparam logic [15:0] BIT_PERIOD_RESET     = 16'd90;
    localparam logic [15:0] ZERO_HIGH_RESET      = 16'd29;
    localparam logic [15:0] ONE_HIGH_RESET       = 16'd58;
    localparam logic [9:0]  RESET_PERIODS_RESET  = 10'd225;
    localparam logic [15:0] CHANNEL_ENABLE_RESET = 16'h0000;

    typedef struct packed {
        logic [15:0] bit_period_ticks;
        logic [15:0] zero_high_ticks;
        logic [15:0] one_high_ticks;
        logic [9:0]  reset_bit_periods;
        logic [15:0] channel_enable;
    } cfg_t;

    typedef struct packed {
        logic        start_frame;
        logic        column_valid;
        logic [63:0] column_low_bytes;
        logic [63:0] column_high_bytes;
        logic [15:0] byte_present;
        logic        column_last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pin_levels;
        logic        column_taken;
        logic        busy_res;
        logic        frame_done;
        logic        underrun;
    } out_item_t;

endpackage

// File: rtl/pled_core.sv
module pled_core #(
    parameter int NUM_CHANNELS = pled_pkg::CHANNELS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  pled_pkg::in_item_t  item,
    input  pled_pkg::cfg_t      cfg,
    output pled_pkg::out_item_t result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    localparam logic [15:0] EN_MASK = 16'((32'd1 << NUM_CHANNELS) - 32'd1);

    phase_t                  phase_reg, phase_next;
    logic [15:0]             tick_reg, tick_next;
    logic [2:0]              bit_idx_reg, bit_idx_next;
    logic [9:0]              reset_cnt_reg, reset_cnt_next;
    logic                    cur_last_reg, cur_last_next;
    logic                    pend_last_reg, pend_last_next;
    logic                    pend_full_reg, pend_full_next;

    logic [7:0]              cur_bytes_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] cur_present_reg;
    logic [63:0]             pend_low_reg;
    logic [63:0]             pend_high_reg;
    logic [15:0]             pend_present_reg;

    logic [127:0]            pend_col;
    logic [16:0]             tick_inc;
    logic                    period_end;
    logic [9:0]              reset_inc;
    logic [15:0]             en;
    logic [pled_pkg::CHANNELS_MAX-1:0] ones;
    logic                    boundary;
    logic                    load;
    logic [15:0]             pins;
    logic                    busy;
    logic                    done;
    logic                    under;
    logic                    taken;

    assign pend_col   = {pend_high_reg, pend_low_reg};
    assign tick_inc   = {1'b0, tick_reg} + 17'd1;
    assign period_end = tick_inc >= {1'b0, cfg.bit_period_ticks};
    assign reset_inc  = reset_cnt_reg + 10'd1;
    assign en         = cfg.channel_enable & EN_MASK;

    // bit position 7 - index is the inverted index
    always_comb
    begin
        ones = '0;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            ones[k] = cur_present_reg[k] & cur_bytes_reg[k][~bit_idx_reg];
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_idx_next   = bit_idx_reg;
        reset_cnt_next = reset_cnt_reg;
        cur_last_next  = cur_last_reg;
        pend_last_next = pend_last_reg;
        pend_full_next = pend_full_reg;
        boundary       = 1'b0;
        load           = 1'b0;
        pins           = '0;
        busy           = 1'b0;
        done           = 1'b0;
        under          = 1'b0;
        taken          = 1'b0;

        case (phase_reg)
            PH_RESET:
            begin
                busy = 1'b1;
                if (period_end)
                begin
                    tick_next      = '0;
                    reset_cnt_next = reset_inc;
                    if (reset_inc >= cfg.reset_bit_periods)
                    begin
                        boundary = 1'b1;
                    end
                end
                else
                begin
                    tick_next = tick_inc[15:0];
                end
            end
            PH_DATA:
            begin
                busy = 1'b1;
                if (tick_reg < cfg.one_high_ticks)
                begin
                    pins = (tick_reg < cfg.zero_high_ticks) ? en : (en & ones);
                end
                if (period_end)
                begin
                    tick_next = '0;
                    if (bit_idx_reg == 3'd7)
                    begin
                        boundary = 1'b1;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                    end
                end
                else
                begin
                    tick_next = tick_inc[15:0];
                end
            end
            default:
            begin
                if (item.start_frame)
                begin
                    phase_next     = PH_RESET;
                    tick_next      = '0;
                    bit_idx_next   = '0;
                    reset_cnt_next = '0;
                    cur_last_next  = 1'b0;
                end
            end
        endcase

        if (boundary)
        begin
            if (cur_last_reg)
            begin
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else if (pend_full_reg)
            begin
                load           = 1'b1;
                cur_last_next  = pend_last_reg;
                pend_full_next = 1'b0;
                phase_next     = PH_DATA;
                bit_idx_next   = '0;
                tick_next      = '0;
            end
            else
            begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                under      = 1'b1;
            end
            if (done)
            begin
                tick_next      = '0;
                bit_idx_next   = '0;
                reset_cnt_next = '0;
            end
        end

        if (item.column_valid && !pend_full_reg)
        begin
            taken          = 1'b1;
            pend_full_next = 1'b1;
            pend_last_next = item.column_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_idx_reg   <= '0;
            reset_cnt_reg <= '0;
            cur_last_reg  <= 1'b0;
            pend_last_reg <= 1'b0;
            pend_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_idx_reg   <= bit_idx_next;
            reset_cnt_reg <= reset_cnt_next;
            cur_last_reg  <= cur_last_next;
            pend_last_reg <= pend_last_next;
            pend_full_reg <= pend_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                cur_bytes_reg[k] <= pend_col[k*8 +: 8];
            end
            cur_present_reg <= pend_present_reg[NUM_CHANNELS-1:0];
        end
        if (advance && taken)
        begin
            pend_low_reg     <= item.column_low_bytes;
            pend_high_reg    <= item.column_high_bytes;
            pend_present_reg <= item.byte_present;
        end
    end

    assign result.pin_levels   = pins;
    assign result.column_taken = taken;
    assign result.busy_res     = busy;
    assign result.frame_done   = done;
    assign result.underrun     = under;

endmodule

// File: rtl/parallel_led_pulse_width_encoder_unit.sv
// Parallel pulse-width encoder for up to sixteen single-wire LED chains.
// Input channel (in_valid / in_stall / in_data): one transfer is one tick of
// the bit timer and may start a frame and offer a column of bytes.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// input transfer, in order: pin levels, column taken, busy, done, underrun.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// timing registers and channel enables, for the user to write only while the
// block is idle (the block does not enforce it). Each input transfer is held
// in the input register, then its result in the result register.
// Throughput: one transfer per cycle while the receiver does not stall; the
// tick logic is a single pass of compares and muxes between the input and
// result registers. When the receiver stalls, the result register holds and the input
// register backs up, raising in_stall in the same cycle.
// Reset: frame state goes idle, the column buffer empties, the timing
// registers take their default values and no result is pending.
module parallel_led_pulse_width_encoder_unit #(
    parameter int NUM_CHANNELS = pled_pkg::CHANNELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pled_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pled_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pled_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data
);

    pled_pkg::cfg_t      cfg_reg;
    logic                s1_valid_reg;
    pled_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg;
    pled_pkg::out_item_t out_data_reg;
    pled_pkg::out_item_t result;
    logic                out_free;
    logic                advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period_ticks  <= pled_pkg::BIT_PERIOD_RESET;
            cfg_reg.zero_high_ticks   <= pled_pkg::ZERO_HIGH_RESET;
            cfg_reg.one_high_ticks    <= pled_pkg::ONE_HIGH_RESET;
            cfg_reg.reset_bit_periods <= pled_pkg::RESET_PERIODS_RESET;
            cfg_reg.channel_enable    <= pled_pkg::CHANNEL_ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pled_pkg::CFG_BIT_PERIOD:     cfg_reg.bit_period_ticks  <= cfg_data;
                pled_pkg::CFG_ZERO_HIGH:      cfg_reg.zero_high_ticks   <= cfg_data;
                pled_pkg::CFG_ONE_HIGH:       cfg_reg.one_high_ticks    <= cfg_data;
                pled_pkg::CFG_RESET_PERIODS:  cfg_reg.reset_bit_periods <= cfg_data[9:0];
                pled_pkg::CFG_CHANNEL_ENABLE: cfg_reg.channel_enable    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    pled_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_underrun_ends_frame : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.underrun |-> out_data_reg.frame_done)
        else $error("underrun without frame end");

    a_done_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.frame_done |-> out_data_reg.busy_res)
        else $error("frame end outside a frame");

    a_pins_only_busy : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.pin_levels != '0) |-> out_data_reg.busy_res)
        else $error("pins driven while idle");

    a_stall_from_output : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled without output backpressure");

endmodule

// File: test/parallel_led_pulse_width_encoder_unit_tb.sv
`timescale 1ns / 100ps

module parallel_led_pulse_width_encoder_unit_tb;

    localparam int CYCLE_LIMIT = 300000;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_RESET,
        FR_DATA
    } frame_phase_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    pled_pkg::in_item_t               in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    pled_pkg::out_item_t              out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [pled_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]                      cfg_data = '0;

    // timing registers as the encoder sees them
    logic [15:0] reg_bit_period = pled_pkg::BIT_PERIOD_RESET;
    logic [15:0] reg_zero_high = pled_pkg::ZERO_HIGH_RESET;
    logic [15:0] reg_one_high = pled_pkg::ONE_HIGH_RESET;
    logic [9:0]  reg_reset_periods = pled_pkg::RESET_PERIODS_RESET;
    logic [15:0] reg_enable = pled_pkg::CHANNEL_ENABLE_RESET;

    // frame state
    frame_phase_t enc_phase = FR_IDLE;
    logic [15:0]  enc_tick = '0;
    logic [2:0]   enc_bit = '0;
    logic [9:0]   enc_resets = '0;
    logic [127:0] cur_bytes = '0;
    logic [15:0]  cur_present = '0;
    logic         cur_last = 1'b0;
    logic [127:0] held_bytes = '0;
    logic [15:0]  held_present = '0;
    logic         held_last = 1'b0;
    logic         held_full = 1'b0;

    pled_pkg::in_item_t  tick_queue[$];
    pled_pkg::out_item_t due_outputs[$];
    pled_pkg::out_item_t next_due;
    int        mismatches = 0;
    int        cycles = 0;
    int        in_gap = 0;
    logic      in_steady = 1'b0;
    int        out_hold = 0;
    int        out_draw;
    logic      out_steady = 1'b0;

    parallel_led_pulse_width_encoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic pled_pkg::out_item_t encode_tick(input pled_pkg::in_item_t t);
        pled_pkg::out_item_t r;
        logic [15:0] ones;
        logic        at_boundary;
        logic        was_full;
        int          k;
        r = '0;
        ones = '0;
        at_boundary = 1'b0;
        was_full = held_full;
        case (enc_phase)
            FR_RESET:
            begin
                r.busy_res = 1'b1;
                if (enc_tick + 17'd1 >= reg_bit_period)
                begin
                    enc_tick = '0;
                    enc_resets = enc_resets + 10'd1;
                    if (enc_resets >= reg_reset_periods)
                        at_boundary = 1'b1;
                end
                else
                    enc_tick = enc_tick + 16'd1;
            end
            FR_DATA:
            begin
                r.busy_res = 1'b1;
                for (k = 0; k < 16; k++)
                    ones[k] = cur_present[k] & cur_bytes[8 * k + 7 - enc_bit];
                if (enc_tick < reg_one_high)
                    r.pin_levels = (enc_tick < reg_zero_high) ? reg_enable
                                                              : (reg_enable & ones);
                if (enc_tick + 17'd1 >= reg_bit_period)
                begin
                    enc_tick = '0;
                    if (enc_bit == 3'd7)
                        at_boundary = 1'b1;
                    else
                        enc_bit = enc_bit + 3'd1;
                end
                else
                    enc_tick = enc_tick + 16'd1;
            end
            default:
            begin
                if (t.start_frame)
                begin
                    enc_phase = FR_RESET;
                    enc_tick = '0;
                    enc_bit = '0;
                    enc_resets = '0;
                    cur_last = 1'b0;
                end
            end
        endcase

        if (at_boundary)
        begin
            if (cur_last)
            begin
                enc_phase = FR_IDLE;
                r.frame_done = 1'b1;
            end
            else if (held_full)
            begin
                cur_bytes = held_bytes;
                cur_present = held_present;
                cur_last = held_last;
                held_full = 1'b0;
                enc_phase = FR_DATA;
                enc_bit = '0;
                enc_tick = '0;
            end
            else
            begin
                enc_phase = FR_IDLE;
                r.frame_done = 1'b1;
                r.underrun = 1'b1;
            end
            if (r.frame_done)
            begin
                enc_tick = '0;
                enc_bit = '0;
                enc_resets = '0;
            end
        end

        // buffer fill sees the occupancy from the start of the tick
        if (t.column_valid && !was_full)
        begin
            held_bytes = {t.column_high_bytes, t.column_low_bytes};
            held_present = t.byte_present;
            held_last = t.column_last;
            held_full = 1'b1;
            r.column_taken = 1'b1;
        end
        return r;
    endfunction

    function automatic pled_pkg::in_item_t column(input logic start, input logic valid,
                                                  input logic [63:0] low,
                                                  input logic [63:0] high,
                                                  input logic [15:0] present,
                                                  input logic last);
        pled_pkg::in_item_t t;
        t.start_frame = start;
        t.column_valid = valid;
        t.column_low_bytes = low;
        t.column_high_bytes = high;
        t.byte_present = present;
        t.column_last = last;
        return t;
    endfunction

    function automatic pled_pkg::in_item_t random_tick(input int start_pct,
                                                       input int valid_pct,
                                                       input int last_pct);
        logic [63:0] low;
        logic [63:0] high;
        logic [15:0] present;
        int          pick;
        low = {$urandom, $urandom};
        high = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            low = '1;
            high = '1;
        end
        else if (pick == 1)
        begin
            low = '0;
            high = '0;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            present = 16'h0000;
        else if (pick < 4)
            present = 16'($urandom_range(0, 65535));
        else
            present = 16'hffff;
        return column($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < valid_pct,
                      low, high, present, $urandom_range(0, 99) < last_pct);
    endfunction

    task automatic write_reg(input pled_pkg::cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            pled_pkg::CFG_BIT_PERIOD:     reg_bit_period = value;
            pled_pkg::CFG_ZERO_HIGH:      reg_zero_high = value;
            pled_pkg::CFG_ONE_HIGH:       reg_one_high = value;
            pled_pkg::CFG_RESET_PERIODS:  reg_reset_periods = value[9:0];
            pled_pkg::CFG_CHANNEL_ENABLE: reg_enable = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (tick_queue.size() != 0 || in_valid || due_outputs.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_traffic(input logic [15:0] period, input logic [15:0] zero_high,
                               input logic [15:0] one_high, input logic [9:0] resets,
                               input logic [15:0] enable, input int count);
        int left;
        int len;
        int kind;
        int spct;
        int vpct;
        int lpct;
        write_reg(pled_pkg::CFG_BIT_PERIOD, period);
        write_reg(pled_pkg::CFG_ZERO_HIGH, zero_high);
        write_reg(pled_pkg::CFG_ONE_HIGH, one_high);
        write_reg(pled_pkg::CFG_RESET_PERIODS, {6'd0, resets});
        write_reg(pled_pkg::CFG_CHANNEL_ENABLE, enable);
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            len = $urandom_range(8, 60);
            if (len > left)
                len = left;
            left = left - len;
            if (kind < 6)
            begin
                // frame with a steady column supply
                spct = 2;
                vpct = 90;
                lpct = 12;
                tick_queue.push_back(random_tick(100, vpct, lpct));
                len = len - 1;
            end
            else if (kind < 8)
            begin
                // starved supply, frames end in underrun
                spct = 20;
                vpct = 20;
                lpct = 10;
            end
            else
            begin
                spct = 50;
                vpct = 50;
                lpct = 50;
            end
            repeat (len) tick_queue.push_back(random_tick(spct, vpct, lpct));
        end
        drain();
    endtask

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_outputs.push_back(encode_tick(in_data));
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    in_data  <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        in_steady <= !in_steady;
                    in_gap   <= in_steady ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (due_outputs.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                mismatches++;
            end
            else
            begin
                next_due = due_outputs.pop_front();
                if (out_data.pin_levels !== next_due.pin_levels)
                begin
                    $error("pin_levels: expected %h, got %h",
                           next_due.pin_levels, out_data.pin_levels);
                    mismatches++;
                end
                if (out_data.column_taken !== next_due.column_taken)
                begin
                    $error("column_taken: expected %b, got %b",
                           next_due.column_taken, out_data.column_taken);
                    mismatches++;
                end
                if (out_data.busy_res !== next_due.busy_res)
                begin
                    $error("busy_res: expected %b, got %b",
                           next_due.busy_res, out_data.busy_res);
                    mismatches++;
                end
                if (out_data.frame_done !== next_due.frame_done)
                begin
                    $error("frame_done: expected %b, got %b",
                           next_due.frame_done, out_data.frame_done);
                    mismatches++;
                end
                if (out_data.underrun !== next_due.underrun)
                begin
                    $error("underrun: expected %b, got %b",
                           next_due.underrun, out_data.underrun);
                    mismatches++;
                end
            end
            if ($urandom_range(0, 39) == 0)
                out_steady <= !out_steady;
            out_draw = out_steady ? 0 : $urandom_range(0, 5);
            out_hold  <= out_draw;
            out_stall <= (out_draw != 0);
        end
        else if (out_hold > 1)
            out_hold <= out_hold - 1;
        else
        begin
            out_hold  <= 0;
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int p;
        int z;
        int o;
        int i;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // two-tick bits, zero reset length acting as one period
        run_traffic(16'd2, 16'd1, 16'd2, 10'd0, 16'hffff, 0);
        // column taken while idle, marked last
        tick_queue.push_back(column(1'b0, 1'b1, '1, 64'h8040_2010_0804_0201,
                                    16'hfff0, 1'b1));
        // start with the buffer full: offered column refused
        tick_queue.push_back(column(1'b1, 1'b1, '0, '0, 16'hffff, 1'b0));
        repeat (2) tick_queue.push_back(column(1'b0, 1'b0, '0, '0, 16'h0000, 1'b0));
        for (n = 0; n < 16; n++)
            tick_queue.push_back(column(n == 5 || n == 11, 1'b0, '0, '0, 16'h0000, 1'b0));
        // start with no column: underrun after the reset pulse
        tick_queue.push_back(column(1'b1, 1'b0, '0, '0, 16'h0000, 1'b0));
        repeat (2) tick_queue.push_back(column(1'b0, 1'b0, '0, '0, 16'h0000, 1'b0));
        drain();

        run_traffic(16'd2, 16'd1, 16'd1, 10'd1, 16'hffff, 100);
        run_traffic(16'd3, 16'd1, 16'd2, 10'd2, 16'($urandom_range(0, 65535)), 100);
        run_traffic(16'd5, 16'd2, 16'd4, 10'd1, 16'($urandom_range(0, 65535)), 100);
        // zero high time above the one high time
        run_traffic(16'd4, 16'd3, 16'd1, 10'd1, 16'hffff, 80);
        // high times running past the bit period
        run_traffic(16'd4, 16'd4, 16'd6, 10'd1, 16'ha5c3, 80);
        run_traffic(16'd2, 16'hffff, 16'hffff, 10'd3, 16'hffff, 60);
        // zero period and zero reset length
        run_traffic(16'd0, 16'd1, 16'd1, 10'd0, 16'h5a5a, 80);
        run_traffic(16'd6, 16'd2, 16'd4, 10'd1, 16'h0000, 80);
        run_traffic(16'hffff, 16'hffff, 16'd1, 10'h3ff, 16'hffff, 40);
        for (i = 0; i < 5; i++)
        begin
            p = $urandom_range(2, 8);
            z = $urandom_range(1, p);
            o = $urandom_range(z, p + 1);
            run_traffic(16'(p), 16'(z), 16'(o), 10'($urandom_range(1, 4)),
                        16'($urandom_range(0, 65535)), 100);
        end

        repeat (8) @(posedge clk);
        if (due_outputs.size() != 0)
        begin
            $error("%0d results never arrived", due_outputs.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: parallel_led_pulse_width_encoder_unit.f
rtl/pled_pkg.sv
rtl/pled_core.sv
rtl/parallel_led_pulse_width_encoder_unit.sv
test/parallel_led_pulse_width_encoder_unit_tb.sv
